// ----- hw/rtl/rcp_pkg.sv -----
// Shared types and constants of the rotator command parser.
// Used by rcp_front, rcp_job_queue, rcp_back and rotator_command_parser_unit.
package rcp_pkg;

    // Digits in an M or W number
    localparam int unsigned NUMBER_DIGITS = 3;

    // Job queue between parser and reply generator
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;

    // Characters
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_L     = 8'h4c;
    localparam logic [7:0] CH_M     = 8'h4d;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_X     = 8'h58;

    // Telnet codes
    localparam logic [7:0] TN_IAC = 8'd255;
    localparam logic [7:0] TN_SB  = 8'd250;
    localparam logic [7:0] TN_SE  = 8'd240;
    localparam logic [7:0] TN_NOP = 8'd241;
    localparam logic [7:0] TN_AYT = 8'd246;

    localparam logic [9:0] AZ_MAX = 10'd999;

    // Parser states
    typedef enum logic [4:0] {
        ST_IDLE   = 5'd0,
        ST_IAC    = 5'd1,
        ST_SB     = 5'd2,
        ST_SB_IAC = 5'd3,
        ST_C      = 5'd4,
        ST_C2     = 5'd5,
        ST_W_AZ1  = 5'd6,
        ST_W_AZ   = 5'd7,
        ST_W_SP   = 5'd8,
        ST_W_EL1  = 5'd9,
        ST_W_EL   = 5'd10,
        ST_W_CR   = 5'd11,
        ST_ACK    = 5'd12,
        ST_M1     = 5'd13,
        ST_M      = 5'd14,
        ST_M_CR   = 5'd15,
        ST_X1     = 5'd16,
        ST_X_CR   = 5'd17
    } parse_state_t;

    // Reply sequence a job produces
    typedef enum logic [1:0] {
        RPL_NONE = 2'd0,  // flags only, one item without a byte
        RPL_ACK  = 2'd1,  // LF CR
        RPL_C    = 2'd2,  // +0ddd CR LF
        RPL_C2   = 2'd3   // +0ddd+0000 CR LF
    } reply_kind_t;

    // Last item index of each reply sequence
    localparam logic [3:0] LAST_NONE = 4'd0;
    localparam logic [3:0] LAST_ACK  = 4'd1;
    localparam logic [3:0] LAST_C    = 4'd6;
    localparam logic [3:0] LAST_C2   = 4'd11;

    // One parsed byte's work for the back end
    typedef struct packed {
        reply_kind_t kind;
        logic [9:0]  azimuth;        // saturated present azimuth for C replies
        logic        azimuth_valid;
        logic [9:0]  new_azimuth;
        logic        elevation_valid;
        logic [9:0]  new_elevation;
        logic        command_end;
        logic        unknown_byte;
    } job_t;

endpackage

// ----- hw/rtl/rcp_front.sv -----
// Parser front end: one received byte per cycle while accept is high, command state machine.
// Emits one rcp_pkg::job_t per byte that causes replies or flags.
module rcp_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       rx_byte,
    input  logic [9:0]       current_azimuth,
    output logic             job_push,
    output rcp_pkg::job_t    job
);

    rcp_pkg::parse_state_t state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [9:0] acc_reg, acc_next;

    logic       is_digit;
    logic [1:0] cnt_add;
    logic [9:0] acc_add;
    logic [9:0] acc_start;
    logic       done_start;
    logic       done_add;
    logic       cmd_end;
    logic       emit;

    // Digit helpers
    always_comb begin
        is_digit  = (rx_byte >= rcp_pkg::CH_ZERO) && (rx_byte <= rcp_pkg::CH_NINE);
        acc_start = {6'd0, rx_byte[3:0]};
        if (32'(cnt_reg) < rcp_pkg::NUMBER_DIGITS) begin
            acc_add = (acc_reg << 3) + (acc_reg << 1) + {6'd0, rx_byte[3:0]};
            cnt_add = cnt_reg + 2'd1;
        end else begin
            acc_add = acc_reg;
            cnt_add = cnt_reg;
        end
        done_start = (rcp_pkg::NUMBER_DIGITS <= 1);
        done_add   = (32'(cnt_add) >= rcp_pkg::NUMBER_DIGITS);
    end

    // Next state and job contents
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        cmd_end    = 1'b0;
        job                 = '0;
        job.kind            = rcp_pkg::RPL_NONE;
        job.azimuth         = (current_azimuth > rcp_pkg::AZ_MAX) ? rcp_pkg::AZ_MAX
                                                                  : current_azimuth;
        case (state_reg)
            rcp_pkg::ST_IDLE: begin
                if (rx_byte == rcp_pkg::TN_IAC) begin
                    state_next = rcp_pkg::ST_IAC;
                end else if (rx_byte == rcp_pkg::CH_C) begin
                    state_next = rcp_pkg::ST_C;
                end else if (rx_byte == rcp_pkg::CH_W) begin
                    state_next = rcp_pkg::ST_W_AZ1;
                end else if (rx_byte == rcp_pkg::CH_R || rx_byte == rcp_pkg::CH_L ||
                             rx_byte == rcp_pkg::CH_S || rx_byte == rcp_pkg::CH_A ||
                             rx_byte == rcp_pkg::CH_E || rx_byte == rcp_pkg::CH_U ||
                             rx_byte == rcp_pkg::CH_D) begin
                    state_next = rcp_pkg::ST_ACK;
                end else if (rx_byte == rcp_pkg::CH_M) begin
                    state_next = rcp_pkg::ST_M1;
                end else if (rx_byte == rcp_pkg::CH_X) begin
                    state_next = rcp_pkg::ST_X1;
                end else begin
                    job.unknown_byte = 1'b1;
                    cmd_end          = 1'b1;
                end
            end
            rcp_pkg::ST_IAC: begin
                if (rx_byte == rcp_pkg::TN_NOP || rx_byte == rcp_pkg::TN_IAC ||
                    rx_byte == rcp_pkg::TN_AYT) begin
                    state_next = rcp_pkg::ST_IDLE;
                end else if (rx_byte == rcp_pkg::TN_SB) begin
                    state_next = rcp_pkg::ST_SB;
                end else begin
                    job.unknown_byte = 1'b1;
                end
            end
            rcp_pkg::ST_SB: begin
                if (rx_byte == rcp_pkg::TN_IAC) state_next = rcp_pkg::ST_SB_IAC;
            end
            rcp_pkg::ST_SB_IAC: begin
                job.unknown_byte = (rx_byte != rcp_pkg::TN_SE);
                cmd_end          = 1'b1;
            end
            rcp_pkg::ST_C: begin
                if (rx_byte == rcp_pkg::CH_TWO) begin
                    state_next = rcp_pkg::ST_C2;
                end else begin
                    if (rx_byte == rcp_pkg::CH_CR) job.kind = rcp_pkg::RPL_C;
                    cmd_end = 1'b1;
                end
            end
            rcp_pkg::ST_C2: begin
                if (rx_byte == rcp_pkg::CH_CR) begin
                    job.kind = rcp_pkg::RPL_C2;
                    cmd_end  = 1'b1;
                end
            end
            rcp_pkg::ST_W_AZ1: begin
                if (is_digit) begin
                    cnt_next = 2'd1;
                    acc_next = acc_start;
                    if (done_start) begin
                        job.azimuth_valid = 1'b1;
                        job.new_azimuth   = acc_start;
                        state_next        = rcp_pkg::ST_W_SP;
                    end else begin
                        state_next = rcp_pkg::ST_W_AZ;
                    end
                end else begin
                    cmd_end = 1'b1;
                end
            end
            rcp_pkg::ST_W_EL1: begin
                if (is_digit) begin
                    cnt_next   = 2'd1;
                    acc_next   = acc_start;
                    state_next = done_start ? rcp_pkg::ST_W_CR : rcp_pkg::ST_W_EL;
                end else begin
                    cmd_end = 1'b1;
                end
            end
            rcp_pkg::ST_M1: begin
                if (is_digit) begin
                    cnt_next   = 2'd1;
                    acc_next   = acc_start;
                    state_next = done_start ? rcp_pkg::ST_M_CR : rcp_pkg::ST_M;
                end else begin
                    cmd_end = 1'b1;
                end
            end
            rcp_pkg::ST_W_AZ: begin
                // non-digits are skipped here
                if (is_digit) begin
                    cnt_next = cnt_add;
                    acc_next = acc_add;
                    if (done_add) begin
                        job.azimuth_valid = 1'b1;
                        job.new_azimuth   = acc_add;
                        state_next        = rcp_pkg::ST_W_SP;
                    end
                end else if (32'(cnt_reg) >= rcp_pkg::NUMBER_DIGITS) begin
                    job.azimuth_valid = 1'b1;
                    job.new_azimuth   = acc_reg;
                    state_next        = rcp_pkg::ST_W_SP;
                end
            end
            rcp_pkg::ST_W_SP: begin
                if (rx_byte == rcp_pkg::CH_SPACE) state_next = rcp_pkg::ST_W_EL1;
            end
            rcp_pkg::ST_W_EL: begin
                if (is_digit) begin
                    cnt_next = cnt_add;
                    acc_next = acc_add;
                    if (done_add) state_next = rcp_pkg::ST_W_CR;
                end else if (32'(cnt_reg) >= rcp_pkg::NUMBER_DIGITS) begin
                    state_next = rcp_pkg::ST_W_CR;
                end
            end
            rcp_pkg::ST_W_CR: begin
                if (rx_byte == rcp_pkg::CH_CR) begin
                    job.elevation_valid = 1'b1;
                    job.new_elevation   = acc_reg;
                    job.kind            = rcp_pkg::RPL_ACK;
                end
                cmd_end = 1'b1;
            end
            rcp_pkg::ST_M: begin
                if (is_digit) begin
                    cnt_next = cnt_add;
                    acc_next = acc_add;
                    if (done_add) state_next = rcp_pkg::ST_M_CR;
                end else begin
                    cmd_end = 1'b1;
                end
            end
            rcp_pkg::ST_M_CR: begin
                if (rx_byte == rcp_pkg::CH_CR) begin
                    job.azimuth_valid = 1'b1;
                    job.new_azimuth   = acc_reg;
                    job.kind          = rcp_pkg::RPL_ACK;
                end
                cmd_end = 1'b1;
            end
            rcp_pkg::ST_X1: begin
                if (is_digit) state_next = rcp_pkg::ST_X_CR;
                else          cmd_end    = 1'b1;
            end
            rcp_pkg::ST_ACK, rcp_pkg::ST_X_CR: begin
                if (rx_byte == rcp_pkg::CH_CR) job.kind = rcp_pkg::RPL_ACK;
                cmd_end = 1'b1;
            end
            default: begin
                job.unknown_byte = 1'b1;
                cmd_end          = 1'b1;
            end
        endcase

        // Command end drops back to idle with a cleared number
        if (cmd_end) begin
            state_next = rcp_pkg::ST_IDLE;
            cnt_next   = 2'd0;
            acc_next   = 10'd0;
        end
        job.command_end = cmd_end;

        emit = (job.kind != rcp_pkg::RPL_NONE) || job.azimuth_valid ||
               job.elevation_valid || job.command_end || job.unknown_byte;
        job_push = accept && emit;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rcp_pkg::ST_IDLE;
            cnt_reg   <= 2'd0;
            acc_reg   <= 10'd0;
        end else if (accept) begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

// ----- hw/rtl/rcp_job_queue.sv -----
// Short first-word-fall-through queue of parser jobs.
// Depends on rcp_pkg for job_t and the queue depth.
module rcp_job_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  rcp_pkg::job_t    push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output rcp_pkg::job_t    head_data
);

    rcp_pkg::job_t entry_reg [rcp_pkg::QUEUE_DEPTH];
    logic [rcp_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [rcp_pkg::QUEUE_AW:0]   count_reg, count_next;

    assign full       = (count_reg == (rcp_pkg::QUEUE_AW + 1)'(rcp_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    // Occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        if (pop && !push) count_next = count_reg - 1'b1;
    end

    // Pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push || pop)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("job queue read while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (rcp_pkg::QUEUE_AW + 1)'(rcp_pkg::QUEUE_DEPTH))
        else $error("job queue count out of range");
`endif

endmodule

// ----- hw/rtl/rcp_back.sv -----
// Reply generator: expands each parser job into result items.
// Depends on rcp_pkg; holds the output register of the result channel.
module rcp_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_valid,
    input  rcp_pkg::job_t    head_data,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_has_reply,
    output logic [7:0]       m_reply_byte,
    output logic             m_last,
    output logic             m_azimuth_valid,
    output logic [9:0]       m_new_azimuth,
    output logic             m_elevation_valid,
    output logic [9:0]       m_new_elevation,
    output logic             m_command_end,
    output logic             m_unknown_byte
);

    rcp_pkg::job_t job_reg;
    logic          job_valid_reg;
    logic [3:0]    idx_reg;

    // Decimal digits of the azimuth, worked out one step per item
    logic [3:0] hund_reg, tens_reg, ones_reg;
    logic [6:0] rem_reg;
    logic [3:0] hund_calc, tens_calc, ones_calc;
    logic [6:0] rem_calc;
    logic [15:0] hund_prod;
    logic [14:0] tens_prod;

    logic       m_valid_reg;
    logic       gen;
    logic [3:0] last_idx;
    logic       is_last;
    logic       item_has;
    logic [7:0] item_byte;

    // Reciprocal multiplies: x*41>>12 = x/100 for x<1000, x*205>>11 = x/10 for x<100
    always_comb begin
        hund_prod = 16'(job_reg.azimuth) * 16'd41;
        hund_calc = hund_prod[15:12];
        rem_calc  = 7'(job_reg.azimuth - (10'(hund_reg) * 10'd100));
        tens_prod = 15'(rem_reg) * 15'd205;
        tens_calc = tens_prod[14:11];
        ones_calc = 4'(rem_reg - (7'(tens_reg) * 7'd10));
    end

    // Item byte for the current index
    always_comb begin
        item_has  = 1'b1;
        item_byte = 8'd0;
        last_idx  = rcp_pkg::LAST_NONE;
        case (job_reg.kind)
            rcp_pkg::RPL_NONE: begin
                item_has = 1'b0;
                last_idx = rcp_pkg::LAST_NONE;
            end
            rcp_pkg::RPL_ACK: begin
                last_idx  = rcp_pkg::LAST_ACK;
                item_byte = (idx_reg == 4'd0) ? rcp_pkg::CH_LF : rcp_pkg::CH_CR;
            end
            rcp_pkg::RPL_C, rcp_pkg::RPL_C2: begin
                last_idx = (job_reg.kind == rcp_pkg::RPL_C) ? rcp_pkg::LAST_C
                                                             : rcp_pkg::LAST_C2;
                if (idx_reg == last_idx) begin
                    item_byte = rcp_pkg::CH_LF;
                end else if (idx_reg == last_idx - 4'd1) begin
                    item_byte = rcp_pkg::CH_CR;
                end else begin
                    case (idx_reg)
                        4'd0, 4'd5: item_byte = rcp_pkg::CH_PLUS;
                        4'd2:       item_byte = rcp_pkg::CH_ZERO | {4'd0, hund_reg};
                        4'd3:       item_byte = rcp_pkg::CH_ZERO | {4'd0, tens_reg};
                        4'd4:       item_byte = rcp_pkg::CH_ZERO | {4'd0, ones_reg};
                        default:    item_byte = rcp_pkg::CH_ZERO;
                    endcase
                end
            end
            default: begin
                item_has = 1'b0;
            end
        endcase
        is_last = (idx_reg == last_idx);
    end

    // Handshake: produce an item whenever the output register frees up
    assign gen     = job_valid_reg && (!m_valid_reg || m_ready);
    assign pop     = head_valid && (!job_valid_reg || (gen && is_last));
    assign m_valid = m_valid_reg;

    // Job register and item index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
        end else if (pop) begin
            job_valid_reg <= 1'b1;
            idx_reg       <= 4'd0;
        end else if (gen) begin
            if (is_last) job_valid_reg <= 1'b0;
            idx_reg <= idx_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) job_reg <= head_data;
    end

    // Digit pipeline steps ride on the first four items
    always_ff @(posedge aclk) begin
        if (gen) begin
            case (idx_reg)
                4'd0:    hund_reg <= hund_calc;
                4'd1:    rem_reg  <= rem_calc;
                4'd2:    tens_reg <= tens_calc;
                4'd3:    ones_reg <= ones_calc;
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (gen) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (gen) begin
            m_has_reply       <= item_has;
            m_reply_byte      <= item_byte;
            m_last            <= is_last;
            m_azimuth_valid   <= is_last && job_reg.azimuth_valid;
            m_new_azimuth     <= is_last ? job_reg.new_azimuth : 10'd0;
            m_elevation_valid <= is_last && job_reg.elevation_valid;
            m_new_elevation   <= is_last ? job_reg.new_elevation : 10'd0;
            m_command_end     <= is_last && job_reg.command_end;
            m_unknown_byte    <= is_last && job_reg.unknown_byte;
        end
    end

endmodule

// ----- hw/rtl/rotator_command_parser_unit.sv -----
// Top level of the antenna rotator command parser.
// Instantiates rcp_front, rcp_job_queue and rcp_back; depends on rcp_pkg.
//
// Takes one received byte per item with the present azimuth, skips telnet IAC
// sequences, parses C, C2, M, W, X and single-letter commands, and emits result
// items: reply bytes ("+0ddd" CR LF, "+0ddd+0000" CR LF, or LF CR) with the
// decoded azimuth/elevation targets and end/unknown flags on the last item of
// each byte. The parser takes one byte per cycle while its four-entry job
// queue has room; the reply generator sends one result item per cycle while
// m_ready is high, so a byte costs one result item (flags only), two (LF CR
// acknowledge), seven (C) or twelve (C2) items on the result channel, and
// that output rate sets the sustained throughput when replies are long.
// Bytes that cause no result produce nothing.
module rotator_command_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic [9:0]  s_current_azimuth,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_has_reply,
    output logic [7:0]  m_reply_byte,
    output logic        m_last,
    output logic        m_azimuth_valid,
    output logic [9:0]  m_new_azimuth,
    output logic        m_elevation_valid,
    output logic [9:0]  m_new_elevation,
    output logic        m_command_end,
    output logic        m_unknown_byte
);

    logic          q_full;
    logic          job_push;
    rcp_pkg::job_t job;
    logic          head_valid;
    rcp_pkg::job_t head_data;
    logic          pop;
    logic          accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    rcp_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .rx_byte         (s_rx_byte),
        .current_azimuth (s_current_azimuth),
        .job_push        (job_push),
        .job             (job)
    );

    rcp_job_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (job_push),
        .push_data  (job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    rcp_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .head_valid        (head_valid),
        .head_data         (head_data),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_has_reply       (m_has_reply),
        .m_reply_byte      (m_reply_byte),
        .m_last            (m_last),
        .m_azimuth_valid   (m_azimuth_valid),
        .m_new_azimuth     (m_new_azimuth),
        .m_elevation_valid (m_elevation_valid),
        .m_new_elevation   (m_new_elevation),
        .m_command_end     (m_command_end),
        .m_unknown_byte    (m_unknown_byte)
    );

`ifndef SYNTHESIS
    a_flags_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !m_azimuth_valid && !m_elevation_valid &&
                               !m_command_end && !m_unknown_byte)
        else $error("flags set on an item that is not the last");

    a_flag_item_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_reply |-> m_last && m_reply_byte == 8'd0)
        else $error("item without reply byte is not a lone last item");

    a_targets_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_azimuth_valid || m_new_azimuth == 10'd0) &&
                    (m_elevation_valid || m_new_elevation == 10'd0))
        else $error("target value without its valid bit");

    a_both_targets: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_azimuth_valid && m_elevation_valid))
        else $error("azimuth and elevation targets on one item");
`endif

endmodule
